/* sv/ssd_pkg.sv */
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, constants and the segment decoder for the seven-segment
// scan driver.
// ----------------------------------------------------------------------------
`default_nettype none

package ssd_pkg;

	localparam int unsigned VALUE_W = 14;
	localparam int unsigned SEG_W   = 7;
	localparam int unsigned PANEL_W = 4;
	localparam int unsigned POS_W   = 2;
	localparam int unsigned CNT_W   = 3;
	localparam int unsigned PROD_W  = 28;
	localparam int unsigned DIGIT_W = 4;

	localparam logic [VALUE_W-1:0] VALUE_MAX  = 14'd9999;
	localparam logic [CNT_W-1:0]   CNT_RESET  = 3'd4;

	// Reciprocal multiplier and right shift for v / 10^k, exact for v <= 9999
	localparam logic [VALUE_W-1:0] RECIP [4] = '{14'd1, 14'd13108, 14'd10486, 14'd8389};
	localparam logic [4:0]         RSHIFT[4] = '{5'd0, 5'd17, 5'd20, 5'd23};

	// Divide by ten, exact for q <= 9999
	localparam logic [VALUE_W-1:0] RECIP10  = 14'd13108;
	localparam int unsigned        RSHIFT10 = 17;

	// Word handed from the front stage to the back stage
	typedef struct packed {
		logic [VALUE_W-1:0] quot;
		logic [POS_W-1:0]   pos;
	} stage_t;

	// Segment pattern, bit0 = A through bit6 = G
	function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] digit);
		logic [SEG_W-1:0] seg;
		unique case (digit)
			4'd0:    seg = 7'h3F;
			4'd1:    seg = 7'h06;
			4'd2:    seg = 7'h5B;
			4'd3:    seg = 7'h4F;
			4'd4:    seg = 7'h66;
			4'd5:    seg = 7'h6D;
			4'd6:    seg = 7'h7D;
			4'd7:    seg = 7'h07;
			4'd8:    seg = 7'h7F;
			4'd9:    seg = 7'h6F;
			default: seg = 7'h00;
		endcase
		return seg;
	endfunction

endpackage

`default_nettype wire

/* sv/ssd_front.sv */
// ----------------------------------------------------------------------------
// ssd_front
// Saturates the value, counts its digits, runs the scan position and
// registers the value scaled down to the selected digit.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [ssd_pkg::VALUE_W-1:0]    value,
	output logic                                s1_valid,
	input  wire logic                           s1_take,
	output ssd_pkg::stage_t                     s1_data
);

	logic                          s1_valid_q;
	ssd_pkg::stage_t               data_s1;
	logic [ssd_pkg::POS_W-1:0]     pos_q;
	logic [ssd_pkg::CNT_W-1:0]     count_q;

	logic                          accept;
	logic [ssd_pkg::VALUE_W-1:0]   sat;
	logic [ssd_pkg::CNT_W-1:0]     ndig;
	logic [ssd_pkg::CNT_W-1:0]     cnt_eff;
	logic [ssd_pkg::POS_W-1:0]     pos_eff;
	logic [ssd_pkg::CNT_W-1:0]     pos_inc;
	logic [ssd_pkg::POS_W-1:0]     pos_next;
	logic [ssd_pkg::POS_W-1:0]     shift;
	logic [ssd_pkg::PROD_W-1:0]    prod;
	logic [ssd_pkg::PROD_W-1:0]    quot_full;

	// Hold the input while the stage register cannot move
	assign in_stall = s1_valid_q && !s1_take;
	assign accept   = in_valid && !in_stall;
	assign s1_valid = s1_valid_q;
	assign s1_data  = data_s1;

	// Saturate and count digits
	always_comb begin
		sat = (value > ssd_pkg::VALUE_MAX) ? ssd_pkg::VALUE_MAX : value;
		if (sat >= 14'd1000)
			ndig = 3'd4;
		else if (sat >= 14'd100)
			ndig = 3'd3;
		else if (sat >= 14'd10)
			ndig = 3'd2;
		else
			ndig = 3'd1;
	end

	// Restart the scan on a count change, then pick the digit and advance
	always_comb begin
		cnt_eff = (ndig != count_q) ? ndig : count_q;
		pos_eff = pos_q;
		if (ndig != count_q || {1'b0, pos_q} >= cnt_eff)
			pos_eff = '0;
		shift    = cnt_eff[ssd_pkg::POS_W-1:0] - 2'd1 - pos_eff;
		pos_inc  = {1'b0, pos_eff} + 3'd1;
		pos_next = (pos_inc >= cnt_eff) ? '0 : pos_inc[ssd_pkg::POS_W-1:0];
	end

	// Scale the value down so the wanted digit is the units digit
	always_comb begin
		prod      = ssd_pkg::PROD_W'(sat) * ssd_pkg::PROD_W'(ssd_pkg::RECIP[shift]);
		quot_full = prod >> ssd_pkg::RSHIFT[shift];
	end

	// Advance scan state on every accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			count_q    <= ssd_pkg::CNT_RESET;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				pos_q   <= pos_next;
				count_q <= cnt_eff;
			end
			if (accept)
				s1_valid_q <= 1'b1;
			else if (s1_take)
				s1_valid_q <= 1'b0;
		end
	end

	// Stage register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1.quot <= quot_full[ssd_pkg::VALUE_W-1:0];
			data_s1.pos  <= pos_eff;
		end
	end

	ap_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= 3'd1 && count_q <= 3'd4)
		else $error("digit count out of range");

	ap_pos_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, pos_q} < count_q)
		else $error("scan position not below digit count");

	ap_big_four: assert property (@(posedge clk) disable iff (!arst_n)
		accept && value >= 14'd1000 |=> count_q == 3'd4)
		else $error("four-digit value did not set count to four");

endmodule

`default_nettype wire

/* sv/ssd_back.sv */
// ----------------------------------------------------------------------------
// ssd_back
// Takes the units digit of the scaled value, decodes its segments and
// holds the result word for the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s1_valid,
	output logic                               s1_take,
	input  wire ssd_pkg::stage_t               s1_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [ssd_pkg::SEG_W-1:0]          segments,
	output logic [ssd_pkg::PANEL_W-1:0]        panel_select
);

	logic                            out_valid_q;
	logic [ssd_pkg::SEG_W-1:0]       seg_q;
	logic [ssd_pkg::PANEL_W-1:0]     panel_q;

	logic [ssd_pkg::PROD_W-1:0]      prod;
	logic [ssd_pkg::VALUE_W-1:0]     tens;
	logic [ssd_pkg::VALUE_W-1:0]     rem;
	logic [ssd_pkg::DIGIT_W-1:0]     digit;

	// Load a new word when the output register is empty or being drained
	assign s1_take      = s1_valid && (!out_valid_q || !out_stall);
	assign out_valid    = out_valid_q;
	assign segments     = seg_q;
	assign panel_select = panel_q;

	// Units digit: q - 10 * (q / 10)
	always_comb begin
		prod  = ssd_pkg::PROD_W'(s1_data.quot) * ssd_pkg::PROD_W'(ssd_pkg::RECIP10);
		tens  = ssd_pkg::VALUE_W'(prod >> ssd_pkg::RSHIFT10);
		rem   = s1_data.quot - ssd_pkg::VALUE_W'({tens, 3'b000} + {tens, 1'b0});
		digit = rem[ssd_pkg::DIGIT_W-1:0];
	end

	// Output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_take)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (s1_take) begin
			seg_q   <= ssd_pkg::seg_of(digit);
			panel_q <= ssd_pkg::PANEL_W'(4'd1 << s1_data.pos);
		end
	end

	ap_panel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot(panel_q))
		else $error("panel select not one-hot");

	ap_take_loads: assert property (@(posedge clk) disable iff (!arst_n)
		s1_take |=> out_valid_q)
		else $error("taken word did not reach output");

	ap_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid |-> rem < 14'd10)
		else $error("digit out of decimal range");

endmodule

`default_nettype wire

/* sv/seven_segment_scan_driver_unit.sv */
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_unit
// Multiplexed four-digit seven-segment scan driver: one refresh word in,
// one segment pattern and panel select out.
// ----------------------------------------------------------------------------
// An accepted word is registered in the front stage, then in the output stage.
// Throughput: one word per cycle while out_stall is low; the scan state updates
// as each word is accepted, and the digit is split out across the two register stages.
// Reset (arst_n low): digit count 4, scan position 0, both stages empty.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_scan_driver_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [ssd_pkg::VALUE_W-1:0]   value,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [ssd_pkg::SEG_W-1:0]          segments,
	output logic [ssd_pkg::PANEL_W-1:0]        panel_select
);

	logic             s1_valid;
	logic             s1_take;
	ssd_pkg::stage_t  s1_data;

	// Front: saturate, count digits, scan and scale
	ssd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.value    (value),
		.s1_valid (s1_valid),
		.s1_take  (s1_take),
		.s1_data  (s1_data)
	);

	// Back: units digit, segment decode, output register
	ssd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.s1_valid     (s1_valid),
		.s1_take      (s1_take),
		.s1_data      (s1_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.segments     (segments),
		.panel_select (panel_select)
	);

endmodule

`default_nettype wire

/* verif/seven_segment_scan_checker.sv */
// ----------------------------------------------------------------------------
// seven_segment_scan_checker
// Watches both word channels of the scan driver, predicts the segment pattern
// and panel select of every accepted refresh word, and compares each
// delivered word against the oldest prediction in order.
// ----------------------------------------------------------------------------

module seven_segment_scan_checker
	import ssd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic [VALUE_W-1:0] value,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic [SEG_W-1:0]   segments,
	input  wire logic [PANEL_W-1:0] panel_select,
	output int                      fail_count,
	output int                      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Glyphs for digits 0..9, bit0 = A through bit6 = G
	localparam logic [SEG_W-1:0] DIGIT_GLYPH [10] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
	};
	localparam int unsigned DECADE [4] = '{1, 10, 100, 1000};

	typedef struct packed {
		logic [SEG_W-1:0]   seg;
		logic [PANEL_W-1:0] panel;
	} lit_digit_t;

	// Shadow scan state
	logic [POS_W-1:0] scan_pos;
	logic [CNT_W-1:0] digit_cnt;

	// Patterns still owed by the block, oldest first
	lit_digit_t lit_digit_q [$];

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	// Work out the digit lit by one refresh word and advance the shadow scan
	function automatic lit_digit_t light_digit(input logic [VALUE_W-1:0] raw);
		int unsigned v;
		int unsigned n;
		int unsigned pos;
		int unsigned shift;
		lit_digit_t  d;
		v = (raw > VALUE_MAX) ? int'(VALUE_MAX) : int'(raw);
		n = (v >= 1000) ? 4 : (v >= 100) ? 3 : (v >= 10) ? 2 : 1;
		// restart the scan whenever the digit count changes
		if (n != digit_cnt) begin
			digit_cnt = CNT_W'(n);
			scan_pos  = '0;
		end
		if (scan_pos >= digit_cnt)
			scan_pos = '0;
		pos     = scan_pos;
		shift   = (digit_cnt - 1 - pos) & 3;
		d.seg   = DIGIT_GLYPH[(v / DECADE[shift]) % 10];
		d.panel = PANEL_W'(1 << pos);
		// wrap at the digit count
		scan_pos = (pos + 1 >= digit_cnt) ? '0 : POS_W'(pos + 1);
		return d;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		lit_digit_t want;
		if (!arst_n) begin
			scan_pos  = '0;
			digit_cnt = CNT_RESET;
		end else begin
			// predict each accepted word
			if (in_valid && !in_stall)
				lit_digit_q.push_back(light_digit(value));
			// compare each delivered word with the oldest prediction
			if (out_valid && !out_stall) begin
				if (lit_digit_q.size() == 0) begin
					$error("unexpected word: segments %h panel_select %h",
						segments, panel_select);
					fail_count++;
				end else begin
					want = lit_digit_q.pop_front();
					if (segments !== want.seg) begin
						$error("segments: expected %h, actual %h", want.seg, segments);
						fail_count++;
					end
					if (panel_select !== want.panel) begin
						$error("panel_select: expected %h, actual %h",
							want.panel, panel_select);
						fail_count++;
					end
				end
			end
		end
		pending = lit_digit_q.size();
	end

endmodule

/* verif/seven_segment_scan_driver_unit_test.sv */
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_unit_test
// Drives refresh words into the scan driver through a directed opening and
// random runs of mostly same-width numbers, under several idle and stall mixes and
// one long output hold; the checker beside the block does the comparing.
// ----------------------------------------------------------------------------

module seven_segment_scan_driver_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ssd_pkg::*;

	localparam int NUM_PHASES = 5;
	localparam int PHASE_WORDS = 80;
	localparam int HOLD_LEN = 64;

	// Sender idle and receiver stall odds per phase, in percent
	localparam int IDLE_ODDS  [NUM_PHASES] = '{0, 81, 0, 20, 0};
	localparam int STALL_ODDS [NUM_PHASES] = '{0, 0, 81, 20, 0};
	localparam int HOLD_PHASE = 4;

	// Boundaries, saturation, all-ones, then runs that wrap the scan
	localparam logic [VALUE_W-1:0] OPENING_WORDS [24] = '{
		14'd0, 14'd9, 14'd10, 14'd99, 14'd100, 14'd999, 14'd1000, 14'd9999,
		14'd10000, 14'd16383,
		14'd1234, 14'd1234, 14'd1234, 14'd1234, 14'd1234,
		14'd56, 14'd56, 14'd56,
		14'd789, 14'd789, 14'd789, 14'd789,
		14'd5, 14'd5
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [VALUE_W-1:0] value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [SEG_W-1:0]   segments;
	logic [PANEL_W-1:0] panel_select;

	int fail_count;
	int pending;
	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	always #6 clk = ~clk;

	seven_segment_scan_driver_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.segments     (segments),
		.panel_select (panel_select)
	);

	seven_segment_scan_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.segments     (segments),
		.panel_select (panel_select),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// Receiver: random stall, or one long hold when asked
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Offer one word after a random gap and hold it until taken
	task automatic send_word(input logic [VALUE_W-1:0] v);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Drop valid and wait until every predicted word has come out
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
	endtask

	// Random number with the given digit count; four digits may overflow
	function automatic logic [VALUE_W-1:0] word_of_width(input int unsigned n);
		case (n)
			1:       return VALUE_W'($urandom_range(9));
			2:       return VALUE_W'($urandom_range(99, 10));
			3:       return VALUE_W'($urandom_range(999, 100));
			default: return ($urandom_range(3) == 0) ? VALUE_W'($urandom_range(16383, 10000))
			                                         : VALUE_W'($urandom_range(9999, 1000));
		endcase
	endfunction

	initial begin : stimulus
		int          sent;
		int unsigned width;
		int unsigned run_len;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening
		foreach (OPENING_WORDS[i])
			send_word(OPENING_WORDS[i]);
		settle();

		// random runs, mostly steady widths so the scan cycles fully
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			idle_pct  = IDLE_ODDS[ph];
			stall_pct = STALL_ODDS[ph];
			@(posedge clk);
			hold_req <= (ph == HOLD_PHASE);
			sent = 0;
			while (sent < PHASE_WORDS) begin
				if ($urandom_range(9) == 0) begin
					send_word(VALUE_W'($urandom_range(16383)));
					sent++;
				end else begin
					width   = $urandom_range(4, 1);
					run_len = $urandom_range(9, 1);
					repeat (run_len) begin
						send_word(word_of_width(width));
						sent++;
					end
				end
			end
			settle();
		end

		// watch for stray words, then give the verdict
		repeat (8) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

/* seven_segment_scan_driver_unit.f */
sv/ssd_pkg.sv
sv/ssd_front.sv
sv/ssd_back.sv
sv/seven_segment_scan_driver_unit.sv
verif/seven_segment_scan_checker.sv
verif/seven_segment_scan_driver_unit_test.sv
